// ----- design/binary_mmc_bit_predictor_defines.svh -----
// assertion macros shared by the predictor modules
// depends on nothing; included by the modules that assert
`ifndef BINARY_MMC_BIT_PREDICTOR_DEFINES_SVH
`define BINARY_MMC_BIT_PREDICTOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BMMC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define BMMC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bmmc_pkg.sv -----
// shared types and constants of the binary mmc bit predictor
// depends on nothing; used by every module of the block but bmmc_ram
package bmmc_pkg;

   localparam int ORDER_WIDTH     = 5;
   localparam int LIMIT_WIDTH     = 18;
   localparam int EPOCH_WIDTH     = 8;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [EPOCH_WIDTH-1:0] EPOCH_MAX   = {EPOCH_WIDTH{1'b1}};
   localparam logic [EPOCH_WIDTH-1:0] EPOCH_FIRST = EPOCH_WIDTH'(1);

   localparam logic [ORDER_WIDTH-1:0] PHASE_RUNNING = 5'd31;
   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET   = 5'd8;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET   = 18'd100000;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONTEXT_ORDER = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTRY_LIMIT   = 4'd1;

   typedef enum logic [1:0] {
      MODE_FILL,
      MODE_FIRST,
      MODE_PREDICT
   } mode_type;

   // control of the item held in the update stage
   typedef struct packed {
      mode_type                  mode;
      logic                      sample_bit;
      logic                      restart;
      logic [EPOCH_WIDTH-1:0]    epoch;
      logic                      fwd;
   } item_type;

endpackage

// ----- design/bmmc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module bmmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bmmc_front.sv -----
// input side: context, warm-up phase, epoch, clearing pass and table read issue
// depends on bmmc_pkg and the assertion header
`include "binary_mmc_bit_predictor_defines.svh"

module bmmc_front #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bmmc_pkg::ORDER_WIDTH-1:0]    cfg_order,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_sample_bit,
   input  logic                                req_restart,
   input  logic                                s1_done,
   input  logic                                upd_wr_en,
   input  logic [MAX_ORDER-1:0]                upd_wr_addr,
   output logic                                s1_valid,
   output bmmc_pkg::item_type                  s1_item,
   output logic [MAX_ORDER-1:0]                s1_addr,
   output logic                                rd_en,
   output logic [MAX_ORDER-1:0]                rd_addr,
   output logic                                sweep_wr_en,
   output logic [MAX_ORDER-1:0]                sweep_wr_addr
);

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_SWEEP = 1'b1;
   localparam logic [bmmc_pkg::ORDER_WIDTH-1:0] ORDER_TOP =
      bmmc_pkg::ORDER_WIDTH'(MAX_ORDER);

   logic                                state_ff, state_in;
   logic [MAX_ORDER-1:0]                sweep_cnt_ff, sweep_cnt_in;
   logic [bmmc_pkg::EPOCH_WIDTH-1:0]    epoch_ff, epoch_in;
   logic [MAX_ORDER-1:0]                context_ff, context_in;
   logic [bmmc_pkg::ORDER_WIDTH-1:0]    phase_ff, phase_in;
   logic                                s1_valid_ff, s1_valid_in;
   bmmc_pkg::item_type                  s1_item_ff, s1_item_in;
   logic [MAX_ORDER-1:0]                s1_addr_ff, s1_addr_in;

   logic [bmmc_pkg::ORDER_WIDTH-1:0]    ord;
   logic [MAX_ORDER-1:0]                ord_mask;
   logic [MAX_ORDER-1:0]                ctx_base;
   logic [bmmc_pkg::ORDER_WIDTH-1:0]    ph_base;
   logic [MAX_ORDER:0]                  ctx_shift;
   logic                                wrap_hold;
   logic                                accept;
   logic                                sweep_start;
   bmmc_pkg::mode_type                  mode;
   logic [bmmc_pkg::ORDER_WIDTH-1:0]    phase_step;

   always_comb begin
      if (cfg_order == '0) begin
         ord = bmmc_pkg::ORDER_WIDTH'(1);
      end else if (cfg_order > ORDER_TOP) begin
         ord = ORDER_TOP;
      end else begin
         ord = cfg_order;
      end
      for (int i = 0; i < MAX_ORDER; i++) begin
         ord_mask[i] = (bmmc_pkg::ORDER_WIDTH'(i) < ord);
      end
   end

   assign ctx_base  = req_restart ? '0 : context_ff;
   assign ph_base   = req_restart ? '0 : phase_ff;
   assign ctx_shift = {ctx_base, req_sample_bit};

   always_comb begin
      phase_step = ph_base;
      if (ph_base != bmmc_pkg::PHASE_RUNNING) begin
         if (ph_base < ord) begin
            mode       = bmmc_pkg::MODE_FILL;
            phase_step = ph_base + 1'b1;
         end else begin
            mode       = bmmc_pkg::MODE_FIRST;
            phase_step = bmmc_pkg::PHASE_RUNNING;
         end
      end else begin
         mode = bmmc_pkg::MODE_PREDICT;
      end
   end

   // a restart that would wrap the epoch waits for a clearing pass
   assign wrap_hold   = req_restart && (epoch_ff == bmmc_pkg::EPOCH_MAX);
   assign req_ready   = (state_ff == ST_RUN) && !wrap_hold && (!s1_valid_ff || s1_done);
   assign accept      = req_valid && req_ready;
   assign sweep_start = (state_ff == ST_RUN) && req_valid && wrap_hold && !s1_valid_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      epoch_in     = epoch_ff;
      context_in   = context_ff;
      phase_in     = phase_ff;
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      s1_addr_in   = s1_addr_ff;

      if (s1_done) begin
         s1_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (&sweep_cnt_ff) begin
               state_in = ST_RUN;
               epoch_in = bmmc_pkg::EPOCH_FIRST;
            end
         end
         ST_RUN: begin
            if (sweep_start) begin
               state_in     = ST_SWEEP;
               sweep_cnt_in = '0;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase

      if (accept) begin
         if (req_restart) begin
            epoch_in = epoch_ff + 1'b1;
         end
         context_in            = ctx_shift[MAX_ORDER-1:0] & ord_mask;
         phase_in              = phase_step;
         s1_valid_in           = 1'b1;
         s1_addr_in            = ctx_base;
         s1_item_in.mode       = mode;
         s1_item_in.sample_bit = req_sample_bit;
         s1_item_in.restart    = req_restart;
         s1_item_in.epoch      = req_restart ? epoch_ff + 1'b1 : epoch_ff;
         // row written back this very cycle: ram still returns old data
         s1_item_in.fwd        = upd_wr_en && (upd_wr_addr == ctx_base);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         epoch_ff     <= '0;
         context_ff   <= '0;
         phase_ff     <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         epoch_ff     <= epoch_in;
         context_ff   <= context_in;
         phase_ff     <= phase_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_addr_ff <= s1_addr_in;
   end

   assign s1_valid      = s1_valid_ff;
   assign s1_item       = s1_item_ff;
   assign s1_addr       = s1_addr_ff;
   assign rd_en         = accept;
   assign rd_addr       = ctx_base;
   assign sweep_wr_en   = (state_ff == ST_SWEEP);
   assign sweep_wr_addr = sweep_cnt_ff;

   `BMMC_ASSERT_IMP(a_no_accept_in_sweep, state_ff == ST_SWEEP, !accept,
      "input transfer during clearing pass")
   `BMMC_ASSERT_IMP(a_epoch_live, state_ff == ST_RUN, epoch_ff != '0,
      "epoch zero outside clearing pass")
   `BMMC_ASSERT_IMP(a_no_wrap, accept && req_restart, epoch_ff != bmmc_pkg::EPOCH_MAX,
      "epoch wrapped without clearing pass")

endmodule

// ----- design/bmmc_update.sv -----
// update stage: counter pair decision, write-back, entry count, result register
// depends on bmmc_pkg and the assertion header
`include "binary_mmc_bit_predictor_defines.svh"

module bmmc_update #(
   parameter int MAX_ORDER   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [bmmc_pkg::LIMIT_WIDTH-1:0]             entry_limit,
   input  logic                                         s1_valid,
   input  bmmc_pkg::item_type                           s1_item,
   input  logic [MAX_ORDER-1:0]                         s1_addr,
   input  logic [bmmc_pkg::EPOCH_WIDTH+2*COUNT_WIDTH-1:0] rd_data,
   output logic                                         s1_done,
   output logic                                         wr_en,
   output logic [MAX_ORDER-1:0]                         wr_addr,
   output logic [bmmc_pkg::EPOCH_WIDTH+2*COUNT_WIDTH-1:0] wr_data,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic                                         rsp_predicted_bit,
   output logic                                         rsp_prediction_made,
   output logic                                         rsp_warming_up,
   output logic                                         rsp_table_full
);

   localparam int ROW_W = bmmc_pkg::EPOCH_WIDTH + 2 * COUNT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [ROW_W-1:0]                    wr_row_ff, wr_row_in;
   logic [bmmc_pkg::LIMIT_WIDTH-1:0]    entry_count_ff, entry_count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_pred_ff, rsp_made_ff, rsp_warm_ff, rsp_full_ff;

   logic [ROW_W-1:0]                    row_sel;
   logic                                hit;
   logic [COUNT_WIDTH-1:0]              c0, c1, n0, n1, gcnt, obs;
   logic                                guess;
   logic [bmmc_pkg::LIMIT_WIDTH-1:0]    cnt_base, cnt_new;
   logic                                can_create;
   logic                                do_write, made, pred, warm, full;

   assign s1_done = s1_valid && (!rsp_valid_ff || rsp_ready);

   assign row_sel = s1_item.fwd ? wr_row_ff : rd_data;
   // rows tagged with an older epoch read as cleared
   assign hit  = (row_sel[ROW_W-1 -: bmmc_pkg::EPOCH_WIDTH] == s1_item.epoch);
   assign c0   = hit ? row_sel[COUNT_WIDTH-1:0] : '0;
   assign c1   = hit ? row_sel[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
   assign guess = !(c0 > c1);
   assign gcnt  = guess ? c1 : c0;
   assign obs   = s1_item.sample_bit ? c1 : c0;

   assign cnt_base   = s1_item.restart ? '0 : entry_count_ff;
   assign can_create = (cnt_base < entry_limit);

   always_comb begin
      n0       = c0;
      n1       = c1;
      do_write = 1'b0;
      made     = 1'b0;
      pred     = 1'b0;
      warm     = 1'b0;
      cnt_new  = cnt_base;
      unique case (s1_item.mode)
         bmmc_pkg::MODE_FILL: begin
            warm = 1'b1;
         end
         bmmc_pkg::MODE_FIRST, bmmc_pkg::MODE_PREDICT: begin
            warm = (s1_item.mode == bmmc_pkg::MODE_FIRST);
            if ((s1_item.mode == bmmc_pkg::MODE_FIRST) || (gcnt == '0)) begin
               if (can_create) begin
                  do_write = 1'b1;
                  cnt_new  = cnt_base + 1'b1;
                  if (s1_item.sample_bit) begin
                     n1 = COUNT_WIDTH'(1);
                  end else begin
                     n0 = COUNT_WIDTH'(1);
                  end
               end
            end else begin
               made     = 1'b1;
               pred     = guess;
               do_write = 1'b1;
               if (obs != COUNT_MAX) begin
                  if (s1_item.sample_bit) begin
                     n1 = c1 + 1'b1;
                  end else begin
                     n0 = c0 + 1'b1;
                  end
               end
            end
         end
         default: begin
            warm = 1'b1;
         end
      endcase
   end

   assign full    = (cnt_new >= entry_limit);
   assign wr_en   = s1_done && do_write;
   assign wr_addr = s1_addr;
   assign wr_data = {s1_item.epoch, n1, n0};

   always_comb begin
      wr_row_in      = wr_row_ff;
      entry_count_in = entry_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_done) begin
         entry_count_in = cnt_new;
         rsp_valid_in   = 1'b1;
         if (do_write) begin
            wr_row_in = wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_row_ff <= wr_row_in;
      if (s1_done) begin
         rsp_pred_ff <= pred;
         rsp_made_ff <= made;
         rsp_warm_ff <= warm;
         rsp_full_ff <= full;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_bit   = rsp_pred_ff;
   assign rsp_prediction_made = rsp_made_ff;
   assign rsp_warming_up      = rsp_warm_ff;
   assign rsp_table_full      = rsp_full_ff;

   `BMMC_ASSERT_NXT(a_count_step, 1'b1,
      (entry_count_ff == $past(entry_count_ff)) ||
      (entry_count_ff == $past(entry_count_ff) + 1'b1) || (entry_count_ff == '0),
      "entry count moved by more than one")
   `BMMC_ASSERT_IMP(a_made_not_warm, rsp_valid_ff && rsp_made_ff, !rsp_warm_ff,
      "prediction reported during warm-up")

endmodule

// ----- design/binary_mmc_bit_predictor.sv -----
// top level of the binary mmc bit predictor: configuration registers and wiring
// depends on bmmc_pkg, bmmc_ram, bmmc_front and bmmc_update
//
// Usage:
// - req_ channel: one sample bit per transfer, with req_restart to begin a new
//   sequence (table, context, entry count and warm-up cleared before the bit).
// - rsp_ channel: exactly one result per input, in order: predicted bit,
//   prediction flag, warm-up flag and table-full flag.
// - csr_ channel: index 0 context order, index 1 entry limit; always ready,
//   other indexes ignored. Write only while no item is in flight.
// - Path: an input passes the update stage, then the output register.
// - Throughput: one item per cycle while rsp_ready is high and no clearing pass
//   runs; the counter pair of a context is read from one ram with a registered
//   read and written back, a row just written being forwarded to the next item.
// - Reset: a clearing pass writes every ram row with req_ready low. Restarts
//   retag the table by epoch; the 255th restart after reset and every 254th
//   after that first wait for the same clearing pass.
// - Stall: a result waits in the output register while rsp_ready is low; the
//   next item still enters and waits in the update stage, after which
//   req_ready drops until the output register frees.
module binary_mmc_bit_predictor #(
   parameter int MAX_ORDER   = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_sample_bit,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_predicted_bit,
   output logic                                   rsp_prediction_made,
   output logic                                   rsp_warming_up,
   output logic                                   rsp_table_full,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bmmc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bmmc_pkg::LIMIT_WIDTH-1:0]       csr_data
);

   localparam int ROW_W = bmmc_pkg::EPOCH_WIDTH + 2 * COUNT_WIDTH;
   localparam int ROWS  = 1 << MAX_ORDER;

   logic [bmmc_pkg::ORDER_WIDTH-1:0]  context_order_ff, context_order_in;
   logic [bmmc_pkg::LIMIT_WIDTH-1:0]  entry_limit_ff, entry_limit_in;

   logic                      s1_valid, s1_done;
   bmmc_pkg::item_type        s1_item;
   logic [MAX_ORDER-1:0]      s1_addr;
   logic                      rd_en;
   logic [MAX_ORDER-1:0]      rd_addr;
   logic [ROW_W-1:0]          rd_data;
   logic                      upd_wr_en;
   logic [MAX_ORDER-1:0]      upd_wr_addr;
   logic [ROW_W-1:0]          upd_wr_data;
   logic                      sweep_wr_en;
   logic [MAX_ORDER-1:0]      sweep_wr_addr;
   logic                      ram_wr_en;
   logic [MAX_ORDER-1:0]      ram_wr_addr;
   logic [ROW_W-1:0]          ram_wr_data;

   assign csr_ready = 1'b1;

   always_comb begin
      context_order_in = context_order_ff;
      entry_limit_in   = entry_limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bmmc_pkg::CSR_CONTEXT_ORDER:
               context_order_in = csr_data[bmmc_pkg::ORDER_WIDTH-1:0];
            bmmc_pkg::CSR_ENTRY_LIMIT:
               entry_limit_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         context_order_ff <= bmmc_pkg::ORDER_RESET;
         entry_limit_ff   <= bmmc_pkg::LIMIT_RESET;
      end else begin
         context_order_ff <= context_order_in;
         entry_limit_ff   <= entry_limit_in;
      end
   end

   // clearing pass and update stage never write in the same cycle
   assign ram_wr_en   = sweep_wr_en || upd_wr_en;
   assign ram_wr_addr = sweep_wr_en ? sweep_wr_addr : upd_wr_addr;
   assign ram_wr_data = sweep_wr_en ? '0 : upd_wr_data;

   bmmc_front #(
      .MAX_ORDER (MAX_ORDER)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg_order      (context_order_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_bit (req_sample_bit),
      .req_restart    (req_restart),
      .s1_done        (s1_done),
      .upd_wr_en      (upd_wr_en),
      .upd_wr_addr    (upd_wr_addr),
      .s1_valid       (s1_valid),
      .s1_item        (s1_item),
      .s1_addr        (s1_addr),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .sweep_wr_en    (sweep_wr_en),
      .sweep_wr_addr  (sweep_wr_addr)
   );

   bmmc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmmc_update #(
      .MAX_ORDER   (MAX_ORDER),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .clock               (clock),
      .reset               (reset),
      .entry_limit         (entry_limit_ff),
      .s1_valid            (s1_valid),
      .s1_item             (s1_item),
      .s1_addr             (s1_addr),
      .rd_data             (rd_data),
      .s1_done             (s1_done),
      .wr_en               (upd_wr_en),
      .wr_addr             (upd_wr_addr),
      .wr_data             (upd_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_bit   (rsp_predicted_bit),
      .rsp_prediction_made (rsp_prediction_made),
      .rsp_warming_up      (rsp_warming_up),
      .rsp_table_full      (rsp_table_full)
   );

endmodule
